@@ design/mrw_pkg.sv @@
package mrw_pkg;

  localparam int unsigned NumWidthDefault = 32;

  // Controller states.
  typedef enum logic [3:0] {
    StIdle,
    StShift,
    StWitness,
    StPowStart,
    StPowMul,
    StPowSqr,
    StCheck,
    StLoopSqr,
    StLoopCheck,
    StDone
  } state_e;

  // Reduction unit operations.
  typedef enum logic [1:0] {
    OpWit,
    OpAccMul,
    OpBaseSqr,
    OpXSqr
  } op_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic shift_d;
    logic start;
    op_e  op;
    logic init_pow;
    logic set_result;
    logic res_verdict;
    logic res_screened;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic le1;
    logic le3;
    logic even;
    logic d_even;
    logic busy;
    logic e_zero;
    logic e_lsb;
    logic x_one;
    logic x_nm1;
    logic r_more;
  } sts_t;

endpackage

@@ design/mrw_modred.sv @@
// Restoring bit-serial reduction: rem = (a * b) mod m, or word mod m.
// The product or word is loaded first, then one dividend bit is shifted in per cycle.
module mrw_modred #(
  parameter int unsigned W = mrw_pkg::NumWidthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             word_sel_i,
  input  logic [31:0]      word_i,
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     b_i,
  input  logic [W-1:0]     m_i,
  output logic             busy_o,
  output logic [W-1:0]     rem_o
);
  import mrw_pkg::*;

  // The dividend register holds either a full product or the 32-bit random word.
  localparam int unsigned PW = (2 * W > 32) ? 2 * W : 32;
  localparam int unsigned CntW = $clog2(PW + 1);

  logic [PW-1:0]   prod_q, prod_d;
  logic [2*W-1:0]  mult;
  logic [W:0]      rem_q, rem_d;
  logic [W-1:0]    m_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [W+1:0]    trial;

  assign mult = a_i * b_i;

  // One shift-subtract step.
  always_comb begin
    trial = {rem_q, prod_q[PW-1]} - {2'b00, m_q};
    prod_d = prod_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      if (word_sel_i) begin
        prod_d = PW'(word_i);
      end else begin
        prod_d = PW'(mult);
      end
      rem_d = '0;
      cnt_d = CntW'(PW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      prod_d = {prod_q[PW-2:0], 1'b0};
      if (!trial[W+1]) begin
        rem_d = trial[W:0];
      end else begin
        rem_d = {rem_q[W-1:0], prod_q[PW-1]};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q <= rem_d;
    if (start_i) begin
      m_q <= m_i;
    end
  end

  assign busy_o = busy_q;
  assign rem_o = rem_q[W-1:0];

endmodule

@@ design/mrw_datapath.sv @@
// Datapath: operand registers, exponent shifter and the shared reduction unit.
module mrw_datapath #(
  parameter int unsigned W = mrw_pkg::NumWidthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mrw_pkg::cmd_t    cmd_i,
  input  logic [31:0]      candidate_i,
  input  logic [31:0]      random_word_i,
  output mrw_pkg::sts_t    sts_o,
  output logic             verdict_o,
  output logic             screened_o
);
  import mrw_pkg::*;

  localparam int unsigned RW = $clog2(W + 1);

  logic [W-1:0]  n_q, d_q, acc_q, base_q, nm1;
  logic [31:0]   rnd_q;
  logic [RW-1:0] r_q;
  logic          verdict_q, screened_q;
  logic [W-1:0]  red_a, red_b, red_m, red_rem;
  logic          red_busy;
  logic          red_word;

  assign nm1 = n_q - 1'b1;

  // The witness step reduces the whole 32-bit random word by n-4.
  assign red_word = (cmd_i.op == OpWit);

  always_comb begin
    red_m = n_q;
    red_a = acc_q;
    red_b = base_q;
    case (cmd_i.op)
      OpWit: begin
        red_m = n_q - W'(4);
      end
      OpAccMul: begin
        red_a = acc_q;
        red_b = base_q;
      end
      OpBaseSqr: begin
        red_a = base_q;
        red_b = base_q;
      end
      OpXSqr: begin
        red_a = acc_q;
        red_b = acc_q;
      end
      default: ;
    endcase
  end

  mrw_modred #(.W(W)) u_red (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .word_sel_i (red_word),
    .word_i     (rnd_q),
    .a_i        (red_a),
    .b_i        (red_b),
    .m_i        (red_m),
    .busy_o     (red_busy),
    .rem_o      (red_rem)
  );

  logic busy_prev_q;
  op_e  op_q;
  logic done_pulse;
  assign done_pulse = busy_prev_q && !red_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_prev_q <= 1'b0;
      verdict_q <= 1'b0;
      screened_q <= 1'b0;
    end else begin
      busy_prev_q <= red_busy;
      if (cmd_i.set_result) begin
        verdict_q <= cmd_i.res_verdict;
        screened_q <= cmd_i.res_screened;
      end
    end
  end

  // Operand registers; results land when the reduction finishes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q <= cmd_i.op;
    end
    if (cmd_i.load) begin
      n_q <= candidate_i[W-1:0];
      rnd_q <= random_word_i;
      d_q <= candidate_i[W-1:0] - 1'b1;
      r_q <= '0;
    end else if (cmd_i.shift_d) begin
      d_q <= d_q >> 1;
      r_q <= r_q + 1'b1;
    end else if (cmd_i.init_pow) begin
      acc_q <= W'(1);
    end else if (done_pulse) begin
      case (op_q)
        OpWit:     base_q <= red_rem + W'(2);
        OpAccMul:  acc_q <= red_rem;
        OpBaseSqr: begin
          base_q <= red_rem;
          d_q <= d_q >> 1;
        end
        OpXSqr: begin
          acc_q <= red_rem;
          r_q <= r_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts_o.le1 = candidate_i[W-1:0] <= W'(1);
    sts_o.le3 = candidate_i[W-1:0] <= W'(3);
    sts_o.even = !candidate_i[0];
    sts_o.d_even = !d_q[0];
    sts_o.busy = red_busy || busy_prev_q;
    sts_o.e_zero = d_q == '0;
    sts_o.e_lsb = d_q[0];
    sts_o.x_one = acc_q == W'(1);
    sts_o.x_nm1 = acc_q == nm1;
    sts_o.r_more = r_q > RW'(1);
  end

  assign verdict_o = verdict_q;
  assign screened_o = screened_q;

endmodule

@@ design/mrw_ctrl.sv @@
// Controller: sequences screen, split, witness, exponentiation and squaring loop.
module mrw_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  mrw_pkg::sts_t sts_i,
  output mrw_pkg::cmd_t cmd_o
);
  import mrw_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q;
    cmd_o = '0;
    cmd_o.op = OpWit;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i && !out_valid_q) begin
          cmd_o.load = 1'b1;
          if (sts_i.le1 || (sts_i.even && !sts_i.le3)) begin
            cmd_o.set_result = 1'b1;
            cmd_o.res_screened = 1'b1;
            out_valid_d = 1'b1;
          end else if (sts_i.le3) begin
            cmd_o.set_result = 1'b1;
            cmd_o.res_verdict = 1'b1;
            cmd_o.res_screened = 1'b1;
            out_valid_d = 1'b1;
          end else begin
            state_d = StShift;
          end
        end
      end
      StShift: begin
        if (sts_i.d_even) begin
          cmd_o.shift_d = 1'b1;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.op = OpWit;
          state_d = StWitness;
        end
      end
      StWitness: begin
        if (!sts_i.busy) begin
          cmd_o.init_pow = 1'b1;
          state_d = StPowStart;
        end
      end
      StPowStart: begin
        if (sts_i.e_zero) begin
          state_d = StCheck;
        end else if (sts_i.e_lsb) begin
          cmd_o.start = 1'b1;
          cmd_o.op = OpAccMul;
          state_d = StPowMul;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.op = OpBaseSqr;
          state_d = StPowSqr;
        end
      end
      StPowMul: begin
        if (!sts_i.busy) begin
          cmd_o.start = 1'b1;
          cmd_o.op = OpBaseSqr;
          state_d = StPowSqr;
        end
      end
      StPowSqr: begin
        if (!sts_i.busy) begin
          state_d = StPowStart;
        end
      end
      StCheck: begin
        if (sts_i.x_one || sts_i.x_nm1) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_verdict = 1'b1;
          state_d = StDone;
        end else if (sts_i.r_more) begin
          cmd_o.start = 1'b1;
          cmd_o.op = OpXSqr;
          state_d = StLoopSqr;
        end else begin
          cmd_o.set_result = 1'b1;
          state_d = StDone;
        end
      end
      StLoopSqr: begin
        if (!sts_i.busy) begin
          state_d = StLoopCheck;
        end
      end
      StLoopCheck: begin
        if (sts_i.x_nm1) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_verdict = 1'b1;
          state_d = StDone;
        end else if (sts_i.x_one || !sts_i.r_more) begin
          cmd_o.set_result = 1'b1;
          state_d = StDone;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.op = OpXSqr;
          state_d = StLoopSqr;
        end
      end
      StDone: begin
        out_valid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o = (state_q != StIdle) || out_valid_q;
  assign out_valid_o = out_valid_q;

  // A result is only raised from the idle or done state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StIdle || $past(state_q) == StDone))
    else $error("result raised from a busy state");
  // No reduction starts while one is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |-> !sts_i.busy)
    else $error("reduction started while busy");
  // No input is taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> in_stall_o)
    else $error("input accepted with pending result");

endmodule

@@ design/miller_rabin_witness_round_unit.sv @@
// One Miller-Rabin round per item on a NUM_WIDTH-bit candidate. Small and even
// candidates are answered with screened set, the result standing valid in the cycle
// after acceptance. Other items run on a single shared bit-serial reduction unit:
// one reduction for the witness, up to two per bit of d and one per squaring step,
// at most 2*NUM_WIDTH-1 in all. One item is in flight at a time; the input stalls
// until its result is taken.
module miller_rabin_witness_round_unit #(
  parameter int unsigned NUM_WIDTH = mrw_pkg::NumWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] candidate_i,
  input  logic [31:0] random_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        verdict_o,
  output logic        screened_o
);
  import mrw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mrw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mrw_datapath #(.W(NUM_WIDTH)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .candidate_i   (candidate_i),
    .random_word_i (random_word_i),
    .sts_o         (sts),
    .verdict_o     (verdict_o),
    .screened_o    (screened_o)
  );

endmodule
